@@ src/itfr_pkg.sv @@
// Shared types and constants for the idle-timeout frame receiver.
package itfr_pkg;

    localparam int unsigned LEN_W = 7;

    // Command codes as they arrive on the input item.
    typedef enum logic [2:0] {
        CMD_RX_BYTE  = 3'd0,
        CMD_MS_TICK  = 3'd1,
        CMD_SCAN     = 3'd2,
        CMD_OVERRUN  = 3'd3,
        CMD_READ     = 3'd4
    } t_cmd;

    // Result status codes.
    localparam logic [1:0] ST_BYTE      = 2'd0;
    localparam logic [1:0] ST_NOT_READY = 2'd1;
    localparam logic [1:0] ST_TX_BUSY   = 2'd2;

    // Register index of the gap timeout.
    localparam logic REG_CHAR_TIMEOUT = 1'b0;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] rx_byte;
        logic       tx_busy;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       status;
        logic [7:0]       data_byte;
        logic [LEN_W-1:0] frame_length;
        logic             last;
    } t_out_item;

    // One classified command as it waits in the queue.
    typedef struct packed {
        t_cmd       op;
        logic [7:0] rx_byte;
        logic       tx_busy;
    } t_op_entry;

endpackage

@@ src/itfr_front.sv @@
// Command classifier and two-entry command queue.
module itfr_front
    import itfr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_in_item  i_item,
    output logic      o_busy,
    input  logic      i_pop,
    output logic      o_head_vld,
    output t_op_entry o_head
);

    t_op_entry   r_q [0:1];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_fill;
    logic        w_known;
    logic        w_push;
    t_op_entry   w_entry;

    // Unused command codes are taken and dropped here.
    always_comb begin
        w_known = 1'b1;
        w_entry.op      = CMD_RX_BYTE;
        w_entry.rx_byte = i_item.rx_byte;
        w_entry.tx_busy = i_item.tx_busy;
        unique case (i_item.command)
            CMD_RX_BYTE: w_entry.op = CMD_RX_BYTE;
            CMD_MS_TICK: w_entry.op = CMD_MS_TICK;
            CMD_SCAN:    w_entry.op = CMD_SCAN;
            CMD_OVERRUN: w_entry.op = CMD_OVERRUN;
            CMD_READ:    w_entry.op = CMD_READ;
            default:     w_known = 1'b0;
        endcase
    end

    assign o_busy     = (r_fill == 2'd2);
    assign w_push     = i_start && !o_busy && w_known;
    assign o_head_vld = (r_fill != 2'd0);
    assign o_head     = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (w_push && !i_pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (i_pop && !w_push) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

endmodule

@@ src/itfr_back.sv @@
// Receiver state, frame store and read sequencer.
module itfr_back
    import itfr_pkg::*;
#(
    parameter int unsigned FRAME_CAPACITY = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_char_timeout,
    input  logic       i_head_vld,
    input  t_op_entry  i_head,
    output logic       o_pop,
    output logic       o_strobe,
    output t_out_item  o_result
);

    localparam int unsigned IDX_W = (FRAME_CAPACITY > 1) ? $clog2(FRAME_CAPACITY) : 1;
    localparam logic [LEN_W-1:0] CAP = LEN_W'(FRAME_CAPACITY);

    typedef enum logic [3:0] {
        PH_IDLE     = 4'b0001,
        PH_BUSY     = 4'b0010,
        PH_COMPLETE = 4'b0100,
        PH_READY    = 4'b1000
    } t_rx_phase;

    typedef enum logic [1:0] {
        BK_EXEC = 2'b01,
        BK_WALK = 2'b10
    } t_bk_state;

    t_bk_state        r_bk_state, n_bk_state;
    t_rx_phase        r_phase,    n_phase;
    logic [LEN_W-1:0] r_count,    n_count;
    logic [7:0]       r_gap,      n_gap;
    logic             r_err,      n_err;
    logic [LEN_W-1:0] r_latched,  n_latched;
    logic [LEN_W-1:0] r_rd_cnt,   n_rd_cnt;
    logic [LEN_W-1:0] r_walk_len, n_walk_len;
    logic             r_out_vld,  n_out_vld;
    logic [1:0]       r_out_status, n_out_status;
    logic [LEN_W-1:0] r_out_len,  n_out_len;
    logic             r_out_last, n_out_last;
    logic             r_out_mem,  n_out_mem;
    logic [7:0]       r_store [0:FRAME_CAPACITY-1];
    logic [7:0]       r_mem_q;
    logic             w_we;
    logic [LEN_W-1:0] w_base;
    logic             w_walk_last;

    assign w_walk_last = ((r_rd_cnt + LEN_W'(1)) == r_walk_len);

    always_comb begin
        n_bk_state   = r_bk_state;
        n_phase      = r_phase;
        n_count      = r_count;
        n_gap        = r_gap;
        n_err        = r_err;
        n_latched    = r_latched;
        n_rd_cnt     = r_rd_cnt;
        n_walk_len   = r_walk_len;
        n_out_vld    = 1'b0;
        n_out_status = ST_BYTE;
        n_out_len    = '0;
        n_out_last   = 1'b1;
        n_out_mem    = 1'b0;
        o_pop        = 1'b0;
        w_we         = 1'b0;
        w_base       = (r_phase == PH_IDLE) ? '0 : r_count;
        unique case (r_bk_state)
            BK_EXEC: begin
                if (i_head_vld) begin
                    o_pop = 1'b1;
                    unique case (i_head.op)
                        CMD_RX_BYTE: begin
                            if (r_phase == PH_IDLE || r_phase == PH_BUSY) begin
                                n_phase = PH_BUSY;
                                n_count = w_base;
                                // A full frame still restarts the gap timer.
                                if (w_base < CAP) begin
                                    w_we    = 1'b1;
                                    n_count = w_base + LEN_W'(1);
                                end
                                n_gap = (i_char_timeout == 8'd0) ? 8'd1 : i_char_timeout;
                            end
                        end
                        CMD_MS_TICK: begin
                            if (r_gap != 8'd0) begin
                                n_gap = r_gap - 8'd1;
                                if (r_gap == 8'd1 && r_phase == PH_BUSY) begin
                                    n_phase = PH_COMPLETE;
                                end
                            end
                        end
                        CMD_SCAN: begin
                            if (r_err) begin
                                n_phase = PH_IDLE;
                                n_gap   = 8'd0;
                                n_count = '0;
                                n_err   = 1'b0;
                            end else if (r_phase == PH_COMPLETE) begin
                                n_latched = r_count;
                                n_phase   = PH_READY;
                            end
                        end
                        CMD_OVERRUN: begin
                            n_err = 1'b1;
                        end
                        CMD_READ: begin
                            if (i_head.tx_busy) begin
                                n_out_vld    = 1'b1;
                                n_out_status = ST_TX_BUSY;
                            end else if (r_phase != PH_READY) begin
                                n_out_vld    = 1'b1;
                                n_out_status = ST_NOT_READY;
                            end else begin
                                n_latched = '0;
                                n_phase   = PH_IDLE;
                                if (r_latched == '0) begin
                                    n_out_vld = 1'b1;
                                end else begin
                                    n_walk_len = r_latched;
                                    n_rd_cnt   = '0;
                                    n_bk_state = BK_WALK;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            BK_WALK: begin
                n_out_vld  = 1'b1;
                n_out_mem  = 1'b1;
                n_out_len  = r_walk_len;
                n_out_last = w_walk_last;
                n_rd_cnt   = r_rd_cnt + LEN_W'(1);
                if (w_walk_last) begin
                    n_bk_state = BK_EXEC;
                end
            end
            default: n_bk_state = BK_EXEC;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_store[w_base[IDX_W-1:0]] <= i_head.rx_byte;
        end
        r_mem_q <= r_store[r_rd_cnt[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bk_state <= BK_EXEC;
            r_phase    <= PH_IDLE;
            r_count    <= '0;
            r_gap      <= 8'd0;
            r_err      <= 1'b0;
            r_latched  <= '0;
            r_rd_cnt   <= '0;
            r_walk_len <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_bk_state <= n_bk_state;
            r_phase    <= n_phase;
            r_count    <= n_count;
            r_gap      <= n_gap;
            r_err      <= n_err;
            r_latched  <= n_latched;
            r_rd_cnt   <= n_rd_cnt;
            r_walk_len <= n_walk_len;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_len    <= n_out_len;
        r_out_last   <= n_out_last;
        r_out_mem    <= n_out_mem;
    end

    assign o_strobe              = r_out_vld;
    assign o_result.status       = r_out_status;
    assign o_result.data_byte    = r_out_mem ? r_mem_q : 8'd0;
    assign o_result.frame_length = r_out_len;
    assign o_result.last         = r_out_last;

`ifndef SYNTHESIS
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP)
        else $error("byte count beyond capacity");
    a_walk_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bk_state == BK_WALK) |-> (r_phase == PH_IDLE))
        else $error("receiver left idle during a frame read");
    a_walk_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bk_state == BK_WALK && w_walk_last) |=> (r_bk_state == BK_EXEC && r_out_last))
        else $error("frame read did not end on its last byte");
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_status != ST_BYTE) |-> (r_out_last && r_out_len == '0))
        else $error("status-only result not marked last");
`endif

endmodule

@@ src/idle_timeout_frame_receiver.sv @@
// Top level of the idle-timeout frame receiver with its APB register port.
//
// The block gathers received UART bytes into a frame that ends after a gap
// of receive silence. Commands enter on i_item and are taken at a clock edge
// where start is high and busy is low: rx byte, millisecond tick, scan tick,
// overrun error and read frame. Unused command codes are taken and dropped.
// A front stage classifies each command into a two-entry queue, and a back
// stage executes queued commands one per cycle while it is not walking a
// frame. busy is high only while that queue is full. A read of a ready
// frame walks the frame store, one byte per cycle, and the back stage takes
// no other command until the walk is done.
// Each result is shown on o_result for one cycle, marked by o_strobe, and
// the receiver cannot hold it off. With an empty queue, a status-only result
// passes through the queue register and the back stage's output registers
// before it shows on o_result; a frame read first moves the back stage into
// its walk state, and the frame bytes then follow on every cycle.
// Reset (synchronous, active low) returns the receiver to idle, empties the
// queue and sets the gap timeout register to 5; the frame store is not
// cleared, as a read only reaches bytes written in the current frame.
// The gap timeout lies at byte address 0 of the APB port; pready is always
// high. The user must write it only while idle, as the block has no check.
module idle_timeout_frame_receiver
    import itfr_pkg::*;
#(
    parameter int unsigned FRAME_CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in_item    i_item,
    output logic        o_strobe,
    output t_out_item   o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] r_char_timeout;
    logic       w_cfg_wr;
    logic       w_head_vld;
    logic       w_pop;
    t_op_entry  w_head;

    // A write transfer completes in the access cycle; only word 0 is mapped.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CHAR_TIMEOUT);
    assign prdata   = (paddr[2] == REG_CHAR_TIMEOUT) ? {24'd0, r_char_timeout} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_timeout <= 8'd5;
        end else if (w_cfg_wr) begin
            r_char_timeout <= pwdata[7:0];
        end
    end

    // The front stage decodes commands and buffers them for the back stage.
    itfr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_item     (i_item),
        .o_busy     (busy),
        .i_pop      (w_pop),
        .o_head_vld (w_head_vld),
        .o_head     (w_head)
    );

    // The back stage owns the receiver state and produces every result.
    itfr_back #(
        .FRAME_CAPACITY (FRAME_CAPACITY)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_char_timeout (r_char_timeout),
        .i_head_vld     (w_head_vld),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .o_strobe       (o_strobe),
        .o_result       (o_result)
    );

endmodule
